>>> sv/assert_macros.svh
// Assertion macros used by the calibration fit controller.
// Each macro wraps one clocked property, disabled while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mlcf_pkg.sv
// Package for the multichannel linear calibration fit unit.
// Holds payload structs, command and status codes and controller/datapath structs.
`timescale 1ns / 1ps

package mlcf_pkg;

  localparam int OUT_W     = 48;  // Q24.24 result width
  localparam int FRAC_BITS = 24;
  localparam int CH_W      = 4;   // holds a channel number up to eight

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_DEL = 2'd1;
  localparam logic [1:0] CMD_FIT = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_DELETED = 3'd1;
  localparam logic [2:0] ST_NODEL   = 3'd2;
  localparam logic [2:0] ST_FIT     = 3'd3;
  localparam logic [2:0] ST_FEW     = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [23:0] eng_value;
    logic signed [23:0] raw_ch0;
    logic signed [23:0] raw_ch1;
    logic signed [23:0] raw_ch2;
    logic signed [23:0] raw_ch3;
    logic signed [23:0] raw_ch4;
    logic signed [23:0] raw_ch5;
    logic signed [23:0] raw_ch6;
    logic signed [23:0] raw_ch7;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         channel_index;
    logic               fit_ok;
    logic signed [47:0] slope;
    logic signed [47:0] intercept;
    logic [5:0]         point_count;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LATCH  = 4'd1,
    OP_SQ     = 4'd2,
    OP_XY     = 4'd3,
    OP_ACC    = 4'd4,
    OP_PT_END = 4'd5,
    OP_CLEAR  = 4'd6,
    OP_MSTART = 4'd7,
    OP_T1     = 4'd8,
    OP_DEN    = 4'd9,
    OP_NUM    = 4'd10,
    OP_DSTART = 4'd11,
    OP_SLOPE  = 4'd12,
    OP_ICPT   = 4'd13
  } dp_op_t;

  // Operand pairs for the serial multiplier, multiplier first.
  typedef enum logic [2:0] {
    MS_N_SXX  = 3'd0,
    MS_SX_SX  = 3'd1,
    MS_N_SXY  = 3'd2,
    MS_SX_SY  = 3'd3,
    MS_SY_SXX = 3'd4,
    MS_SX_SXY = 3'd5
  } mul_sel_t;

  typedef struct packed {
    dp_op_t          op;
    logic            sub;
    logic [CH_W-1:0] ch;
    logic [CH_W-1:0] rd_ch;
    mul_sel_t        msel;
    logic            emit;
    logic [2:0]      est;
    logic            eok;
    logic            elast;
    logic            epc0;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic few;
    logic den_zero;
    logic mul_busy;
    logic div_busy;
  } dp_sts_t;

endpackage

>>> sv/mlcf_ram.sv
// Generic simple dual-port RAM with a registered read.
// Standalone; used for the point stores of the calibration fit unit.
`timescale 1ns / 1ps

module mlcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/mlcf_ctrl.sv
// Controller of the calibration fit unit: sequences point updates and fits.
// Depends on mlcf_pkg and assert_macros.svh; drives mlcf_dp by command struct.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlcf_ctrl #(
  parameter int CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_cmd,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  mlcf_pkg::dp_sts_t sts,
  output mlcf_pkg::dp_cmd_t dp_cmd,
  output logic              busy
);
  import mlcf_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_RD     = 14'b00000000000010,
    S_SQ     = 14'b00000000000100,
    S_XY     = 14'b00000000001000,
    S_ACC    = 14'b00000000010000,
    S_PTEND  = 14'b00000000100000,
    S_FCH    = 14'b00000001000000,
    S_MSTART = 14'b00000010000000,
    S_MRUN   = 14'b00000100000000,
    S_DCHK   = 14'b00001000000000,
    S_DSTART = 14'b00010000000000,
    S_DRUN   = 14'b00100000000000,
    S_FEMIT  = 14'b01000000000000,
    S_CLR    = 14'b10000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            del_r, del_nxt;
  logic            ok_r, ok_nxt;
  mul_sel_t        msel_r, msel_nxt;
  logic [7:0]      mask_r;
  logic            last_fit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mask_r  <= 8'hFF;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
    end
    ch_r   <= ch_nxt;
    del_r  <= del_nxt;
    ok_r   <= ok_nxt;
    msel_r <= msel_nxt;
  end

  // A fit result is the last one when no selected channel follows it.
  always_comb begin
    last_fit = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((CH_W'(i) > ch_r) && mask_r[i]) begin
        last_fit = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    del_nxt   = del_r;
    ok_nxt    = ok_r;
    msel_nxt  = msel_r;
    dp_cmd    = '0;
    dp_cmd.op    = OP_NONE;
    dp_cmd.msel  = msel_r;
    dp_cmd.sub   = del_r;
    dp_cmd.ch    = ch_r;
    dp_cmd.rd_ch = ch_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ch_nxt    = '0;
          dp_cmd.ch = '0;
          case (in_cmd)
            CMD_ADD: begin
              if (sts.full) begin
                dp_cmd.emit  = 1'b1;
                dp_cmd.est   = ST_FULL;
                dp_cmd.elast = 1'b1;
              end else begin
                dp_cmd.op = OP_LATCH;
                del_nxt   = 1'b0;
                state_nxt = S_SQ;
              end
            end
            CMD_DEL: begin
              if (sts.empty) begin
                dp_cmd.emit  = 1'b1;
                dp_cmd.est   = ST_NODEL;
                dp_cmd.elast = 1'b1;
              end else begin
                del_nxt   = 1'b1;
                state_nxt = S_RD;
              end
            end
            CMD_FIT: begin
              if (sts.few) begin
                dp_cmd.op    = OP_CLEAR;
                dp_cmd.emit  = 1'b1;
                dp_cmd.est   = ST_FEW;
                dp_cmd.elast = 1'b1;
                dp_cmd.epc0  = 1'b1;
              end else begin
                state_nxt = S_FCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        dp_cmd.rd_ch = '0;
        state_nxt    = S_SQ;
      end
      S_SQ: begin
        dp_cmd.op = OP_SQ;
        state_nxt = S_XY;
      end
      S_XY: begin
        dp_cmd.op = OP_XY;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        dp_cmd.op    = OP_ACC;
        dp_cmd.rd_ch = ch_r + 1'b1;
        if (ch_r == CH_W'(CHANNELS - 1)) begin
          state_nxt = S_PTEND;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_PTEND: begin
        dp_cmd.op    = OP_PT_END;
        dp_cmd.emit  = 1'b1;
        dp_cmd.est   = del_r ? ST_DELETED : ST_ADDED;
        dp_cmd.elast = 1'b1;
        dp_cmd.ch    = '0;
        state_nxt    = S_IDLE;
      end
      S_FCH: begin
        if (ch_r == CH_W'(CHANNELS)) begin
          state_nxt = S_CLR;
        end else if (!mask_r[ch_r[2:0]]) begin
          ch_nxt = ch_r + 1'b1;
        end else begin
          msel_nxt  = MS_N_SXX;
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: begin
        dp_cmd.op = OP_MSTART;
        state_nxt = S_MRUN;
      end
      S_MRUN: begin
        if (!sts.mul_busy) begin
          case (msel_r)
            MS_N_SXX: begin
              dp_cmd.op = OP_T1;
              msel_nxt  = MS_SX_SX;
              state_nxt = S_MSTART;
            end
            MS_SX_SX: begin
              dp_cmd.op = OP_DEN;
              state_nxt = S_DCHK;
            end
            MS_N_SXY: begin
              dp_cmd.op = OP_T1;
              msel_nxt  = MS_SX_SY;
              state_nxt = S_MSTART;
            end
            MS_SX_SY: begin
              dp_cmd.op = OP_NUM;
              state_nxt = S_DSTART;
            end
            MS_SY_SXX: begin
              dp_cmd.op = OP_T1;
              msel_nxt  = MS_SX_SXY;
              state_nxt = S_MSTART;
            end
            default: begin
              dp_cmd.op = OP_NUM;
              state_nxt = S_DSTART;
            end
          endcase
        end
      end
      S_DCHK: begin
        if (sts.den_zero) begin
          ok_nxt    = 1'b0;
          state_nxt = S_FEMIT;
        end else begin
          msel_nxt  = MS_N_SXY;
          state_nxt = S_MSTART;
        end
      end
      S_DSTART: begin
        dp_cmd.op = OP_DSTART;
        state_nxt = S_DRUN;
      end
      S_DRUN: begin
        if (!sts.div_busy) begin
          if (msel_r == MS_SX_SY) begin
            dp_cmd.op = OP_SLOPE;
            msel_nxt  = MS_SY_SXX;
            state_nxt = S_MSTART;
          end else begin
            dp_cmd.op = OP_ICPT;
            ok_nxt    = 1'b1;
            state_nxt = S_FEMIT;
          end
        end
      end
      S_FEMIT: begin
        dp_cmd.emit  = 1'b1;
        dp_cmd.est   = ST_FIT;
        dp_cmd.eok   = ok_r;
        dp_cmd.elast = last_fit;
        dp_cmd.epc0  = 1'b1;
        ch_nxt       = ch_r + 1'b1;
        state_nxt    = S_FCH;
      end
      S_CLR: begin
        dp_cmd.op = OP_CLEAR;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  `ASSERT_IMPL(a_mul_free, clk, rst_n, dp_cmd.op == OP_MSTART, !sts.mul_busy, "mul restarted while busy")
  `ASSERT_IMPL(a_div_free, clk, rst_n, dp_cmd.op == OP_DSTART, !sts.div_busy, "div restarted while busy")
  `ASSERT_NEXT(a_mul_runs, clk, rst_n, state_r == S_MSTART, sts.mul_busy, "mul did not start")
  `ASSERT_IMPL(a_fit_chan, clk, rst_n, state_r == S_FEMIT, ch_r < CH_W'(CHANNELS), "fit on bad channel")

endmodule

>>> sv/mlcf_dp.sv
// Datapath of the calibration fit unit: point stores, running sums,
// serial multiplier, restoring divider and result register. Uses mlcf_pkg, mlcf_ram.
`timescale 1ns / 1ps

module mlcf_dp #(
  parameter int CHANNELS    = 8,
  parameter int MAX_POINTS  = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mlcf_pkg::in_t     in_data,
  input  mlcf_pkg::dp_cmd_t cmd,
  output mlcf_pkg::dp_sts_t sts,
  output logic              out_strobe,
  output mlcf_pkg::out_t    out_data
);
  import mlcf_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int SXW    = SB + CW;
  localparam int SQW    = 2 * SB + CW;
  localparam int PW     = SXW + SQW + 1;
  localparam int MCW    = $clog2(SXW);
  localparam int DW     = PW + FRAC_BITS + 1;
  localparam int DCW    = $clog2(DW);
  localparam int QW     = OUT_W + 1;
  localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RAW_D  = MAX_POINTS * CHANNELS;
  localparam int RAW_AW = $clog2(RAW_D);
  localparam int ENG_AW = $clog2(MAX_POINTS);

  function automatic logic signed [SB-1:0] sext(input logic [23:0] f);
    return SB'(f);
  endfunction

  in_t                  in_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic signed [SXW-1:0] seng_r;
  logic signed [SXW-1:0] sx_r  [CHANNELS];
  logic signed [SQW-1:0] sxx_r [CHANNELS];
  logic signed [SQW-1:0] sxy_r [CHANNELS];
  logic signed [2*SB-1:0] prod_r;

  logic [23:0]          raw_f [8];
  logic [CIW-1:0]       idx;
  logic signed [SB-1:0] x_sel, y_sel, m_b;
  logic [SB-1:0]        raw_rd, eng_rd;
  logic                 raw_we;
  logic [RAW_AW-1:0]    raw_wa, raw_ra;
  logic [ENG_AW-1:0]    eng_wa, eng_ra;

  // Serial multiplier.
  logic signed [SXW-1:0] mpl_in;
  logic signed [PW-1:0]  mcd_in;
  logic signed [SXW-1:0] mpl_r;
  logic signed [PW-1:0]  mcd_r, acc_r, t1_r, den_r, num_r;
  logic [MCW-1:0]        mcnt_r;
  logic                  mbusy_r;
  logic                  mlast;

  // Restoring divider.
  logic [DW-1:0]  dvd_r;
  logic [PW-1:0]  dm_r, rem_r, rem_nxt, nm_in, dm_in;
  logic [PW:0]    sh;
  logic           ge;
  logic [QW-1:0]  q_r;
  logic           ovf_r, neg_r, dbusy_r;
  logic [DCW-1:0] dcnt_r;
  logic [QW:0]    q_inc;
  logic [QW-1:0]  mag, limit, mag_sat;
  logic [OUT_W-1:0] div_res;
  logic signed [OUT_W-1:0] slope_r, icpt_r;

  logic  out_v_r;
  out_t  out_r;

  assign raw_f[0] = in_r.raw_ch0;
  assign raw_f[1] = in_r.raw_ch1;
  assign raw_f[2] = in_r.raw_ch2;
  assign raw_f[3] = in_r.raw_ch3;
  assign raw_f[4] = in_r.raw_ch4;
  assign raw_f[5] = in_r.raw_ch5;
  assign raw_f[6] = in_r.raw_ch6;
  assign raw_f[7] = in_r.raw_ch7;

  assign idx   = cmd.ch[CIW-1:0];
  assign x_sel = cmd.sub ? signed'(raw_rd) : sext(raw_f[cmd.ch[2:0]]);
  assign y_sel = cmd.sub ? signed'(eng_rd) : sext(in_r.eng_value);
  assign m_b   = (cmd.op == OP_SQ) ? x_sel : y_sel;

  // Pushes go to the row at the count, pops read the row below it.
  assign raw_we = (cmd.op == OP_SQ) && !cmd.sub;
  assign raw_wa = RAW_AW'(count_r * CHANNELS + idx);
  assign raw_ra = RAW_AW'((count_r - 1'b1) * CHANNELS + cmd.rd_ch);
  assign eng_wa = ENG_AW'(count_r);
  assign eng_ra = ENG_AW'(count_r - 1'b1);

  mlcf_ram #(.WIDTH(SB), .DEPTH(RAW_D)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (raw_wa),
    .wdata (x_sel),
    .raddr (raw_ra),
    .rdata (raw_rd)
  );

  mlcf_ram #(.WIDTH(SB), .DEPTH(MAX_POINTS)) u_eng_ram (
    .clk   (clk),
    .we    ((cmd.op == OP_PT_END) && !cmd.sub),
    .waddr (eng_wa),
    .wdata (y_sel),
    .raddr (eng_ra),
    .rdata (eng_rd)
  );

  always_comb begin
    count_nxt = count_r;
    case (cmd.op)
      OP_PT_END: count_nxt = cmd.sub ? count_r - 1'b1 : count_r + 1'b1;
      OP_CLEAR:  count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  always_comb begin
    case (cmd.msel)
      MS_N_SXX: begin
        mpl_in = SXW'(count_r);
        mcd_in = PW'(sxx_r[idx]);
      end
      MS_SX_SX: begin
        mpl_in = sx_r[idx];
        mcd_in = PW'(sx_r[idx]);
      end
      MS_N_SXY: begin
        mpl_in = SXW'(count_r);
        mcd_in = PW'(sxy_r[idx]);
      end
      MS_SX_SY: begin
        mpl_in = sx_r[idx];
        mcd_in = PW'(seng_r);
      end
      MS_SY_SXX: begin
        mpl_in = seng_r;
        mcd_in = PW'(sxx_r[idx]);
      end
      default: begin
        mpl_in = sx_r[idx];
        mcd_in = PW'(sxy_r[idx]);
      end
    endcase
  end

  assign mlast = (mcnt_r == MCW'(SXW - 1));

  // Divider step and final rounding to nearest with saturation.
  assign nm_in   = num_r[PW-1] ? PW'(-num_r) : PW'(num_r);
  assign dm_in   = den_r[PW-1] ? PW'(-den_r) : PW'(den_r);
  assign sh      = {rem_r, dvd_r[DW-1]};
  assign ge      = (sh >= {1'b0, dm_r});
  assign rem_nxt = ge ? PW'(sh - {1'b0, dm_r}) : PW'(sh);
  assign q_inc   = {1'b0, q_r} + 1'b1;
  assign mag     = q_inc[QW:1];
  assign limit   = neg_r ? (QW'(1) << (OUT_W - 1)) : ((QW'(1) << (OUT_W - 1)) - 1'b1);
  assign mag_sat = (ovf_r || (mag > limit)) ? limit : mag;
  assign div_res = neg_r ? OUT_W'(-mag_sat) : OUT_W'(mag_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      seng_r  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        sx_r[c]  <= '0;
        sxx_r[c] <= '0;
        sxy_r[c] <= '0;
      end
      mbusy_r <= 1'b0;
      dbusy_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      out_v_r <= cmd.emit;
      case (cmd.op)
        OP_XY: begin
          sxx_r[idx] <= cmd.sub ? sxx_r[idx] - SQW'(prod_r) : sxx_r[idx] + SQW'(prod_r);
        end
        OP_ACC: begin
          sxy_r[idx] <= cmd.sub ? sxy_r[idx] - SQW'(prod_r) : sxy_r[idx] + SQW'(prod_r);
          sx_r[idx]  <= cmd.sub ? sx_r[idx] - SXW'(x_sel) : sx_r[idx] + SXW'(x_sel);
        end
        OP_PT_END: begin
          seng_r <= cmd.sub ? seng_r - SXW'(y_sel) : seng_r + SXW'(y_sel);
        end
        OP_CLEAR: begin
          seng_r <= '0;
          for (int c = 0; c < CHANNELS; c++) begin
            sx_r[c]  <= '0;
            sxx_r[c] <= '0;
            sxy_r[c] <= '0;
          end
        end
        default: begin
        end
      endcase
      if (cmd.op == OP_MSTART) begin
        mbusy_r <= 1'b1;
      end else if (mbusy_r && mlast) begin
        mbusy_r <= 1'b0;
      end
      if (cmd.op == OP_DSTART) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && (dcnt_r == DCW'(DW - 1))) begin
        dbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      in_r <= in_data;
    end
    if ((cmd.op == OP_SQ) || (cmd.op == OP_XY)) begin
      prod_r <= x_sel * m_b;
    end
    // Shift-and-add over the multiplier bits; the sign bit has negative weight.
    if (cmd.op == OP_MSTART) begin
      mpl_r  <= mpl_in;
      mcd_r  <= mcd_in;
      acc_r  <= '0;
      mcnt_r <= '0;
    end else if (mbusy_r) begin
      if (mpl_r[0]) begin
        acc_r <= mlast ? acc_r - mcd_r : acc_r + mcd_r;
      end
      mpl_r  <= mpl_r >>> 1;
      mcd_r  <= mcd_r <<< 1;
      mcnt_r <= mcnt_r + 1'b1;
    end
    case (cmd.op)
      OP_T1:    t1_r    <= acc_r;
      OP_DEN:   den_r   <= t1_r - acc_r;
      OP_NUM:   num_r   <= t1_r - acc_r;
      OP_SLOPE: slope_r <= div_res;
      OP_ICPT:  icpt_r  <= div_res;
      default: begin
      end
    endcase
    // The quotient is taken to one extra fraction bit for the rounding step.
    if (cmd.op == OP_DSTART) begin
      neg_r  <= num_r[PW-1] ^ den_r[PW-1];
      dvd_r  <= {nm_in, (FRAC_BITS + 1)'(0)};
      dm_r   <= dm_in;
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      rem_r  <= rem_nxt;
      q_r    <= {q_r[QW-2:0], ge};
      ovf_r  <= ovf_r | q_r[QW-1];
      dvd_r  <= dvd_r << 1;
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.emit) begin
      out_r.status        <= cmd.est;
      out_r.channel_index <= cmd.ch[2:0];
      out_r.fit_ok        <= cmd.eok;
      out_r.slope         <= cmd.eok ? slope_r : '0;
      out_r.intercept     <= cmd.eok ? icpt_r : '0;
      out_r.point_count   <= cmd.epc0 ? 6'd0 : 6'(count_nxt);
      out_r.last          <= cmd.elast;
    end
  end

  assign sts.full     = (count_r == CW'(MAX_POINTS));
  assign sts.empty    = (count_r == '0);
  assign sts.few      = (count_r < CW'(2));
  assign sts.den_zero = (den_r == '0);
  assign sts.mul_busy = mbusy_r;
  assign sts.div_busy = dbusy_r;

  assign out_strobe = out_v_r;
  assign out_data   = out_r;

endmodule

>>> sv/multichannel_linear_calibration_fit_unit.sv
// Top level of the multichannel linear calibration fit unit.
// Joins mlcf_ctrl and mlcf_dp; types from mlcf_pkg.
`timescale 1ns / 1ps

// Usage:
// An item is taken on a rising edge with start high and busy low. cmd add
// pushes a point (engineering value plus one raw reading per channel), cmd
// delete pops the newest point, cmd finish fits every channel selected in
// active_mask and clears the batch. Each result stays on out_data until the
// next, flagged for one cycle by out_strobe; last marks an item's final result.
// The receiver cannot stall, so results are never held back.
// Add walks the channels in turn, updating one channel's sums in the SQ, XY
// and ACC states through the single sample multiplier, then ends in PTEND;
// delete first reads the stack in RD. The result strobes as busy falls.
// Stack full, empty delete and too few points answer without raising busy.
// Finish skips unselected channels; for each selected one the bit-serial
// multiplier forms N*Sxx - Sx*Sx (zero fails the fit), N*Sxy - Sx*Sy and
// Sy*Sxx - Sx*Sxy; the one-bit-per-cycle divider divides the last two by
// the first for slope and intercept; the batch is then cleared. The user
// writes active_mask by cfg_we while busy is low; the block does not check.
// Reset clears the point count, the sums and the mask to all channels; the
// point stores need no clearing.

module multichannel_linear_calibration_fit_unit #(
  parameter int CHANNELS    = 8,
  parameter int MAX_POINTS  = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mlcf_pkg::in_t  in_data,
  output logic           out_strobe,
  output mlcf_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);
  import mlcf_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  mlcf_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_data.cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (dp_sts),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  mlcf_dp #(
    .CHANNELS    (CHANNELS),
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
